[src/htq_pkg.sv]
// ----------------------------------------------------------------------------
// htq_pkg: shared types and codes of the heap timer queue
// Beat payloads, configuration register indexes, operation and status codes,
// and the sequencer states.
// ----------------------------------------------------------------------------
package htq_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_POP    = 3'd3,
    OP_EXPIRE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_STALE     = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_EMPTY     = 3'd4,
    STATUS_NONE_DUE  = 3'd5,
    STATUS_DUPLICATE = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RD,
    S_CHK,
    S_HEAD,
    S_LAST,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  timer_id;
    logic [7:0]  generation;
    logic [47:0] expiration;
    logic [47:0] now_time;
  } htq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_id;
    logic [7:0]  out_generation;
    logic [47:0] out_expiration;
    logic [8:0]  queue_count;
    logic [47:0] head_expiration;
    logic        last;
    logic        more_pending;
  } htq_out_t;

  typedef struct packed {
    logic [8:0] max_entries;
    logic [6:0] burst_limit;
  } htq_cfg_t;

  typedef struct packed {
    logic     valid;
    htq_out_t data;
  } htq_emit_t;

endpackage

[src/htq_ram.sv]
// ----------------------------------------------------------------------------
// htq_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module htq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/htq_ctrl.sv]
// ----------------------------------------------------------------------------
// htq_ctrl: heap sequencer
// Decodes one item, then walks the heap one level at a time through the heap
// RAM, moving a hole and keeping the id-to-slot map RAM in step.
// ----------------------------------------------------------------------------
module htq_ctrl #(
  parameter int HEAP_DEPTH = 256,
  parameter int ID_COUNT   = 256,
  parameter int TIME_BITS  = 48,
  parameter int GEN_BITS   = 8,
  parameter int MAX_BURST  = 64,
  localparam int SB   = $clog2(HEAP_DEPTH),
  localparam int CB   = $clog2(HEAP_DEPTH + 1),
  localparam int MAPD = (ID_COUNT < 256) ? ID_COUNT : 256,
  localparam int MAB  = $clog2(MAPD),
  localparam int ST   = (TIME_BITS < 48) ? TIME_BITS : 48,
  localparam int GB   = (GEN_BITS < 8) ? GEN_BITS : 8,
  localparam int HW   = ST + MAB + GB
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  htq_pkg::htq_in_t    in_data_i,
  input  htq_pkg::htq_cfg_t   cfg_i,
  output htq_pkg::htq_emit_t  emit_o,
  input  logic                emit_ready_i,
  output logic                heap_we_o,
  output logic [SB-1:0]       heap_waddr_o,
  output logic [HW-1:0]       heap_wdata_o,
  output logic                heap_re_o,
  output logic [SB-1:0]       heap_raddr_o,
  input  logic [HW-1:0]       heap_rdata_i,
  output logic                map_we_o,
  output logic [MAB-1:0]      map_waddr_o,
  output logic [SB-1:0]       map_wdata_o,
  output logic                map_re_o,
  output logic [MAB-1:0]      map_raddr_o,
  input  logic [SB-1:0]       map_rdata_i
);

  localparam int LW = SB + 2;

  htq_pkg::state_e  state_q, state_d;
  htq_pkg::status_e status_q, status_d;
  logic [2:0]     op_q, op_d;
  logic [MAB-1:0] id_q, id_d;
  logic [GB-1:0]  gen_q, gen_d;
  logic [ST-1:0]  exp_q, exp_d;
  logic [ST-1:0]  now_q, now_d;
  logic [ST-1:0]  cur_exp_q, cur_exp_d;
  logic [MAB-1:0] cur_id_q, cur_id_d;
  logic [GB-1:0]  cur_gen_q, cur_gen_d;
  logic [ST-1:0]  b_exp_q, b_exp_d;
  logic [MAB-1:0] b_id_q, b_id_d;
  logic [GB-1:0]  b_gen_q, b_gen_d;
  logic           b_sel_q, b_sel_d;
  logic [ST-1:0]  t_exp_q, t_exp_d;
  logic [MAB-1:0] t_id_q, t_id_d;
  logic [GB-1:0]  t_gen_q, t_gen_d;
  logic [SB-1:0]  i_q, i_d;
  logic [CB-1:0]  cnt_q, cnt_d;
  logic [ST-1:0]  head_q, head_d;
  logic [6:0]     k_q, k_d;
  logic           try_down_q, try_down_d;
  logic [MAPD-1:0] valid_q, valid_d;

  logic           acc;
  logic [MAB-1:0] in_id;
  logic [ST-1:0]  in_exp, in_now;
  logic           in_range, is_full, is_dup, head_due_in;
  logic [ST-1:0]  rd_exp;
  logic [MAB-1:0] rd_id;
  logic [GB-1:0]  rd_gen;
  logic [CB-1:0]  cnt_m1;
  logic [SB-1:0]  lastpos, parent;
  logic [LW-1:0]  l_w, r_w, cnt_w;
  logic           l_in, r_in, l_less, r_less, up_stop;
  logic           pos_bad, head_due, expire_ok, emit_last;
  logic [6:0]     eff_burst;

  assign acc      = in_valid_i && in_ready_o;
  assign in_id    = in_data_i.timer_id[MAB-1:0];
  assign in_exp   = in_data_i.expiration[ST-1:0];
  assign in_now   = in_data_i.now_time[ST-1:0];
  assign in_range = 32'(in_data_i.timer_id) < ID_COUNT;
  assign is_full  = (32'(cnt_q) >= HEAP_DEPTH) || (32'(cnt_q) >= 32'(cfg_i.max_entries));
  assign is_dup   = valid_q[in_id];
  assign head_due_in = (cnt_q != '0) && (head_q <= in_now);

  assign rd_exp = heap_rdata_i[HW-1 -: ST];
  assign rd_id  = heap_rdata_i[GB +: MAB];
  assign rd_gen = heap_rdata_i[GB-1:0];

  assign cnt_m1  = cnt_q - CB'(1);
  assign lastpos = cnt_m1[SB-1:0];
  assign parent  = (i_q - SB'(1)) >> 1;
  assign l_w     = LW'({i_q, 1'b1});
  assign r_w     = l_w + LW'(1);
  assign cnt_w   = LW'(cnt_q);
  assign l_in    = l_w < cnt_w;
  assign r_in    = r_w < cnt_w;
  assign l_less  = rd_exp < cur_exp_q;
  assign r_less  = rd_exp < (b_sel_q ? b_exp_q : cur_exp_q);
  assign up_stop = rd_exp <= cur_exp_q;
  assign pos_bad = CB'(map_rdata_i) >= cnt_q;

  always_comb begin
    if (cfg_i.burst_limit == 7'd0) begin
      eff_burst = 7'd1;
    end else if (32'(cfg_i.burst_limit) > MAX_BURST) begin
      eff_burst = 7'(MAX_BURST);
    end else begin
      eff_burst = cfg_i.burst_limit;
    end
  end

  // An expire result closes the item once the burst is spent or the head is
  // no longer due.
  assign head_due  = (cnt_q != '0) && (head_q <= now_q);
  assign expire_ok = (op_q == htq_pkg::OP_EXPIRE) && (status_q == htq_pkg::STATUS_OK);
  assign emit_last = expire_ok ? (((k_q + 7'd1) == eff_burst) || !head_due) : 1'b1;

  assign in_ready_o = (state_q == htq_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      htq_pkg::S_IDLE: begin
        if (acc) begin
          case (in_data_i.op)
            htq_pkg::OP_INSERT: begin
              state_d = (!in_range || is_full || is_dup) ? htq_pkg::S_EMIT : htq_pkg::S_UP;
            end
            htq_pkg::OP_REMOVE, htq_pkg::OP_UPDATE: begin
              state_d = (!in_range || !is_dup) ? htq_pkg::S_EMIT : htq_pkg::S_MAP_RD;
            end
            htq_pkg::OP_POP: begin
              state_d = (cnt_q == '0) ? htq_pkg::S_EMIT : htq_pkg::S_HEAD;
            end
            htq_pkg::OP_EXPIRE: begin
              state_d = head_due_in ? htq_pkg::S_HEAD : htq_pkg::S_EMIT;
            end
            default: begin
              state_d = htq_pkg::S_EMIT;
            end
          endcase
        end
      end
      htq_pkg::S_MAP_RD: begin
        state_d = pos_bad ? htq_pkg::S_EMIT : htq_pkg::S_CHK;
      end
      htq_pkg::S_CHK: begin
        if (rd_gen != gen_q) begin
          state_d = htq_pkg::S_EMIT;
        end else if (op_q == htq_pkg::OP_REMOVE) begin
          state_d = (i_q == lastpos) ? htq_pkg::S_EMIT : htq_pkg::S_LAST;
        end else if (exp_q < rd_exp) begin
          state_d = htq_pkg::S_UP;
        end else if (exp_q > rd_exp) begin
          state_d = htq_pkg::S_DN;
        end else begin
          state_d = htq_pkg::S_EMIT;
        end
      end
      htq_pkg::S_HEAD: begin
        state_d = (cnt_q == CB'(1)) ? htq_pkg::S_EMIT : htq_pkg::S_LAST;
      end
      htq_pkg::S_LAST: begin
        state_d = (i_q == '0) ? htq_pkg::S_DN : htq_pkg::S_UP;
      end
      htq_pkg::S_UP: begin
        state_d = (i_q == '0) ? htq_pkg::S_PLACE : htq_pkg::S_UP_CMP;
      end
      htq_pkg::S_UP_CMP: begin
        if (up_stop) begin
          state_d = try_down_q ? htq_pkg::S_DN : htq_pkg::S_PLACE;
        end else begin
          state_d = htq_pkg::S_UP;
        end
      end
      htq_pkg::S_DN: begin
        state_d = l_in ? htq_pkg::S_DN_L : htq_pkg::S_PLACE;
      end
      htq_pkg::S_DN_L: begin
        if (r_in) begin
          state_d = htq_pkg::S_DN_R;
        end else begin
          state_d = l_less ? htq_pkg::S_DN : htq_pkg::S_PLACE;
        end
      end
      htq_pkg::S_DN_R: begin
        state_d = (r_less || b_sel_q) ? htq_pkg::S_DN : htq_pkg::S_PLACE;
      end
      htq_pkg::S_PLACE: begin
        state_d = htq_pkg::S_EMIT;
      end
      htq_pkg::S_EMIT: begin
        if (emit_ready_i) begin
          state_d = emit_last ? htq_pkg::S_IDLE : htq_pkg::S_HEAD;
        end
      end
      default: begin
        state_d = htq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory ports.
  always_comb begin
    status_d   = status_q;
    op_d       = op_q;
    id_d       = id_q;
    gen_d      = gen_q;
    exp_d      = exp_q;
    now_d      = now_q;
    cur_exp_d  = cur_exp_q;
    cur_id_d   = cur_id_q;
    cur_gen_d  = cur_gen_q;
    b_exp_d    = b_exp_q;
    b_id_d     = b_id_q;
    b_gen_d    = b_gen_q;
    b_sel_d    = b_sel_q;
    t_exp_d    = t_exp_q;
    t_id_d     = t_id_q;
    t_gen_d    = t_gen_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    try_down_d = try_down_q;
    valid_d    = valid_q;
    heap_we_o    = 1'b0;
    heap_waddr_o = i_q;
    heap_wdata_o = heap_rdata_i;
    heap_re_o    = 1'b0;
    heap_raddr_o = '0;
    map_we_o     = 1'b0;
    map_waddr_o  = rd_id;
    map_wdata_o  = i_q;
    map_re_o     = 1'b0;
    map_raddr_o  = in_id;

    case (state_q)
      htq_pkg::S_IDLE: begin
        if (acc) begin
          op_d       = in_data_i.op;
          id_d       = in_id;
          gen_d      = in_data_i.generation[GB-1:0];
          exp_d      = in_exp;
          now_d      = in_now;
          status_d   = htq_pkg::STATUS_OK;
          t_exp_d    = '0;
          t_id_d     = '0;
          t_gen_d    = '0;
          k_d        = '0;
          try_down_d = 1'b0;
          case (in_data_i.op)
            htq_pkg::OP_INSERT: begin
              if (!in_range) begin
                status_d = htq_pkg::STATUS_NOT_FOUND;
              end else if (is_full) begin
                status_d = htq_pkg::STATUS_FULL;
              end else if (is_dup) begin
                status_d = htq_pkg::STATUS_DUPLICATE;
              end else begin
                cur_exp_d = in_exp;
                cur_id_d  = in_id;
                cur_gen_d = in_data_i.generation[GB-1:0];
                i_d       = cnt_q[SB-1:0];
                cnt_d     = cnt_q + CB'(1);
                valid_d[in_id] = 1'b1;
              end
            end
            htq_pkg::OP_REMOVE, htq_pkg::OP_UPDATE: begin
              if (!in_range || !is_dup) begin
                status_d = htq_pkg::STATUS_NOT_FOUND;
              end else begin
                map_re_o = 1'b1;
              end
            end
            htq_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                status_d = htq_pkg::STATUS_EMPTY;
              end else begin
                heap_re_o = 1'b1;
              end
            end
            htq_pkg::OP_EXPIRE: begin
              if (head_due_in) begin
                heap_re_o = 1'b1;
              end else begin
                status_d = htq_pkg::STATUS_NONE_DUE;
              end
            end
            default: begin
              status_d = htq_pkg::STATUS_OK;
            end
          endcase
        end
      end
      htq_pkg::S_MAP_RD: begin
        if (pos_bad) begin
          status_d = htq_pkg::STATUS_NOT_FOUND;
        end else begin
          i_d          = map_rdata_i;
          heap_re_o    = 1'b1;
          heap_raddr_o = map_rdata_i;
        end
      end
      htq_pkg::S_CHK: begin
        if (rd_gen != gen_q) begin
          status_d = htq_pkg::STATUS_STALE;
        end else if (op_q == htq_pkg::OP_REMOVE) begin
          valid_d[id_q] = 1'b0;
          cnt_d         = cnt_m1;
          try_down_d    = 1'b1;
          if (i_q != lastpos) begin
            heap_re_o    = 1'b1;
            heap_raddr_o = lastpos;
          end
        end else begin
          cur_exp_d = exp_q;
          cur_id_d  = rd_id;
          cur_gen_d = rd_gen;
        end
      end
      htq_pkg::S_HEAD: begin
        // The head leaves; the last entry, if another remains, will refill slot 0.
        t_exp_d        = rd_exp;
        t_id_d         = rd_id;
        t_gen_d        = rd_gen;
        valid_d[rd_id] = 1'b0;
        i_d            = '0;
        cnt_d          = cnt_m1;
        try_down_d     = 1'b1;
        if (cnt_q != CB'(1)) begin
          heap_re_o    = 1'b1;
          heap_raddr_o = lastpos;
        end
      end
      htq_pkg::S_LAST: begin
        cur_exp_d = rd_exp;
        cur_id_d  = rd_id;
        cur_gen_d = rd_gen;
      end
      htq_pkg::S_UP: begin
        if (i_q != '0) begin
          heap_re_o    = 1'b1;
          heap_raddr_o = parent;
        end
      end
      htq_pkg::S_UP_CMP: begin
        if (!up_stop) begin
          heap_we_o  = 1'b1;
          map_we_o   = 1'b1;
          i_d        = parent;
          try_down_d = 1'b0;
        end
      end
      htq_pkg::S_DN: begin
        b_sel_d = 1'b0;
        if (l_in) begin
          heap_re_o    = 1'b1;
          heap_raddr_o = l_w[SB-1:0];
        end
      end
      htq_pkg::S_DN_L: begin
        b_exp_d = rd_exp;
        b_id_d  = rd_id;
        b_gen_d = rd_gen;
        b_sel_d = l_less;
        if (r_in) begin
          heap_re_o    = 1'b1;
          heap_raddr_o = r_w[SB-1:0];
        end else if (l_less) begin
          heap_we_o = 1'b1;
          map_we_o  = 1'b1;
          i_d       = l_w[SB-1:0];
        end
      end
      htq_pkg::S_DN_R: begin
        if (r_less) begin
          heap_we_o = 1'b1;
          map_we_o  = 1'b1;
          i_d       = r_w[SB-1:0];
        end else if (b_sel_q) begin
          heap_we_o    = 1'b1;
          heap_wdata_o = {b_exp_q, b_id_q, b_gen_q};
          map_we_o     = 1'b1;
          map_waddr_o  = b_id_q;
          i_d          = l_w[SB-1:0];
        end
      end
      htq_pkg::S_PLACE: begin
        heap_we_o    = 1'b1;
        heap_wdata_o = {cur_exp_q, cur_id_q, cur_gen_q};
        map_we_o     = 1'b1;
        map_waddr_o  = cur_id_q;
      end
      htq_pkg::S_EMIT: begin
        if (emit_ready_i && !emit_last) begin
          k_d       = k_q + 7'd1;
          heap_re_o = 1'b1;
        end
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  // Slot 0 mirrors into the head register whenever it is written.
  always_comb begin
    head_d = head_q;
    if (heap_we_o && (heap_waddr_o == '0)) begin
      head_d = heap_wdata_o[HW-1 -: ST];
    end
  end

  always_comb begin
    emit_o.valid                = (state_q == htq_pkg::S_EMIT);
    emit_o.data.status          = status_q;
    emit_o.data.out_id          = 8'(t_id_q);
    emit_o.data.out_generation  = 8'(t_gen_q);
    emit_o.data.out_expiration  = 48'(t_exp_q);
    emit_o.data.queue_count     = 9'(cnt_q);
    emit_o.data.head_expiration = (cnt_q != '0) ? 48'(head_q) : 48'd0;
    emit_o.data.last            = emit_last;
    emit_o.data.more_pending    = expire_ok && emit_last && head_due;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= htq_pkg::S_IDLE;
      cnt_q      <= '0;
      k_q        <= '0;
      try_down_q <= 1'b0;
      b_sel_q    <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      try_down_q <= try_down_d;
      b_sel_q    <= b_sel_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    op_q      <= op_d;
    id_q      <= id_d;
    gen_q     <= gen_d;
    exp_q     <= exp_d;
    now_q     <= now_d;
    cur_exp_q <= cur_exp_d;
    cur_id_q  <= cur_id_d;
    cur_gen_q <= cur_gen_d;
    b_exp_q   <= b_exp_d;
    b_id_q    <= b_id_d;
    b_gen_q   <= b_gen_d;
    t_exp_q   <= t_exp_d;
    t_id_q    <= t_id_d;
    t_gen_q   <= t_gen_d;
    i_q       <= i_d;
    head_q    <= head_d;
  end

endmodule

[src/heap_timer_queue.sv]
// ----------------------------------------------------------------------------
// heap_timer_queue: timer queue on a binary min-heap
// Insert, remove, re-time, pop and expire timers ordered by expiration.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in channel (in_valid_i / in_ready_o) as one
// beat each; results leave on the out channel (out_valid_o / out_ready_i),
// one beat per result, with last set on the final beat of an item. An
// expire item gives one beat per due timer, up to the burst limit.
// The heap RAM's single read port paces the work: each level needs one
// or two reads before the hole can move. Items are handled one at a time;
// in_ready_o is high only while the sequencer is idle. If the receiver
// stalls, the pending result holds and the sequencer waits at its next one.
// Reset empties the queue, marks every id as not queued and sets
// max_entries to 256 and burst_limit to 16; the user must write the
// configuration only while the block is idle, as the block itself does
// not enforce it. The RAMs need no clearing.
// ----------------------------------------------------------------------------
module heap_timer_queue #(
  parameter int HEAP_DEPTH = 256,
  parameter int ID_COUNT   = 256,
  parameter int TIME_BITS  = 48,
  parameter int GEN_BITS   = 8,
  parameter int MAX_BURST  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  htq_pkg::htq_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output htq_pkg::htq_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [htq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [htq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SB   = $clog2(HEAP_DEPTH);
  localparam int MAPD = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int MAB  = $clog2(MAPD);
  localparam int ST   = (TIME_BITS < 48) ? TIME_BITS : 48;
  localparam int GB   = (GEN_BITS < 8) ? GEN_BITS : 8;
  localparam int HW   = ST + MAB + GB;

  htq_pkg::htq_cfg_t  cfg_q;
  htq_pkg::htq_emit_t emit;
  htq_pkg::htq_out_t  out_q;
  logic               out_valid_q;
  logic               emit_ready;

  logic           heap_we, heap_re;
  logic [SB-1:0]  heap_waddr, heap_raddr;
  logic [HW-1:0]  heap_wdata, heap_rdata;
  logic           map_we, map_re;
  logic [MAB-1:0] map_waddr, map_raddr;
  logic [SB-1:0]  map_wdata, map_rdata;

  // Configuration registers; writes to other indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_entries <= 9'd256;
      cfg_q.burst_limit <= 7'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htq_pkg::REG_MAX_ENTRIES: cfg_q.max_entries <= cfg_data_i[8:0];
        htq_pkg::REG_BURST_LIMIT: cfg_q.burst_limit <= cfg_data_i[6:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Output register: a result is taken from the sequencer whenever the
  // register is empty or its beat is leaving in this cycle.
  assign emit_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit.valid) begin
      out_q <= emit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  htq_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_COUNT   (ID_COUNT),
    .TIME_BITS  (TIME_BITS),
    .GEN_BITS   (GEN_BITS),
    .MAX_BURST  (MAX_BURST)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .heap_we_o    (heap_we),
    .heap_waddr_o (heap_waddr),
    .heap_wdata_o (heap_wdata),
    .heap_re_o    (heap_re),
    .heap_raddr_o (heap_raddr),
    .heap_rdata_i (heap_rdata),
    .map_we_o     (map_we),
    .map_waddr_o  (map_waddr),
    .map_wdata_o  (map_wdata),
    .map_re_o     (map_re),
    .map_raddr_o  (map_raddr),
    .map_rdata_i  (map_rdata)
  );

  // Heap slots: expiration, id and generation of each queued timer.
  htq_ram #(
    .Width (HW),
    .Depth (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  // Slot of each timer id; the valid bits live in the sequencer.
  htq_ram #(
    .Width (SB),
    .Depth (MAPD)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the heap timer queue
// A directed table followed by random phases drives the in channel. An
// in-bench min-heap predicts every result beat, and the out channel is
// compared field by field, under changing idle, stall and capacity settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [47:0] MAX_TIME   = 48'hFFFF_FFFF_FFFF;
  localparam int          DEPTH      = 256;
  localparam int          BURST_CAP  = 64;
  localparam int          SETTLE     = 64;    // cycles to let the sequencer go quiet
  localparam int          QUIET_MAX  = 5000;  // watchdog: cycles with no beat at all
  localparam int          HOLD_LEN   = 400;   // long receiver hold-off
  localparam int          PHASE_LEN  = 72;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  htq_pkg::htq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  htq_pkg::htq_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [htq_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [htq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  heap_timer_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow timer heap. It mirrors the block's heap slots, id map and
  // registers, and turns each accepted item into the result beats it must
  // produce. Those beats wait in pending_results, oldest first.
  // --------------------------------------------------------------------------
  logic [47:0] sh_exp [DEPTH];
  logic [7:0]  sh_id  [DEPTH];
  logic [7:0]  sh_gen [DEPTH];
  bit          id_queued [DEPTH];
  int          id_slot   [DEPTH];
  int          sh_count;
  int          sh_max_entries;
  int          sh_burst;

  htq_pkg::htq_out_t pending_results[$];
  int       errors = 0;

  function automatic void queue_result(htq_pkg::htq_out_t b);
    pending_results.insert(pending_results.size(), b);
  endfunction

  function automatic htq_pkg::htq_out_t take_newest();
    htq_pkg::htq_out_t b;
    b = pending_results[pending_results.size() - 1];
    pending_results.delete(pending_results.size() - 1);
    return b;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [47:0] e;
    logic [7:0]  i, g;
    if (a == b) return;
    e = sh_exp[a]; i = sh_id[a]; g = sh_gen[a];
    sh_exp[a] = sh_exp[b]; sh_id[a] = sh_id[b]; sh_gen[a] = sh_gen[b];
    sh_exp[b] = e; sh_id[b] = i; sh_gen[b] = g;
    id_slot[sh_id[a]] = a;
    id_slot[sh_id[b]] = b;
  endfunction

  function automatic void climb(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      // A child climbs past its parent only when it is strictly earlier.
      if (sh_exp[p] <= sh_exp[i]) break;
      swap_slots(p, i);
      i = p;
    end
  endfunction

  function automatic void descend(int i);
    int best, l, r;
    forever begin
      best = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < sh_count && sh_exp[l] < sh_exp[best]) best = l;
      if (r < sh_count && sh_exp[r] < sh_exp[best]) best = r;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  // Pull slot i out: the tail entry fills the hole and moves whichever
  // way restores order.
  function automatic void pull_slot(int i);
    int tail;
    tail = sh_count - 1;
    id_queued[sh_id[i]] = 1'b0;
    if (i != tail) begin
      swap_slots(i, tail);
      sh_count--;
      if (i > 0 && sh_exp[i] < sh_exp[(i - 1) / 2]) climb(i);
      else descend(i);
    end else begin
      sh_count--;
    end
  endfunction

  function automatic htq_pkg::htq_out_t make_beat(htq_pkg::status_e st, bit with_timer,
                                                  logic [7:0] id, logic [7:0] gen,
                                                  logic [47:0] e);
    htq_pkg::htq_out_t b;
    b = '0;
    b.status = st;
    if (with_timer) begin
      b.out_id = id;
      b.out_generation = gen;
      b.out_expiration = e;
    end
    b.queue_count = sh_count[8:0];
    b.head_expiration = (sh_count != 0) ? sh_exp[0] : 48'd0;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic void predict_results(htq_pkg::htq_in_t it);
    int cap, pos, burst, n;
    logic [47:0] old_e, e;
    logic [7:0]  id, g;
    htq_pkg::htq_out_t b;
    case (it.op)
      htq_pkg::OP_INSERT: begin
        cap = (sh_max_entries < DEPTH) ? sh_max_entries : DEPTH;
        // Full is checked ahead of duplicate.
        if (sh_count >= cap) begin
          queue_result(make_beat(htq_pkg::STATUS_FULL, 0, 0, 0, 0));
        end else if (id_queued[it.timer_id]) begin
          queue_result(make_beat(htq_pkg::STATUS_DUPLICATE, 0, 0, 0, 0));
        end else begin
          sh_exp[sh_count] = it.expiration;
          sh_id[sh_count] = it.timer_id;
          sh_gen[sh_count] = it.generation;
          id_queued[it.timer_id] = 1'b1;
          id_slot[it.timer_id] = sh_count;
          sh_count++;
          climb(sh_count - 1);
          queue_result(make_beat(htq_pkg::STATUS_OK, 0, 0, 0, 0));
        end
      end
      htq_pkg::OP_REMOVE, htq_pkg::OP_UPDATE: begin
        pos = id_slot[it.timer_id];
        if (!id_queued[it.timer_id] || pos >= sh_count) begin
          queue_result(make_beat(htq_pkg::STATUS_NOT_FOUND, 0, 0, 0, 0));
        end else if (sh_gen[pos] != it.generation) begin
          queue_result(make_beat(htq_pkg::STATUS_STALE, 0, 0, 0, 0));
        end else begin
          if (it.op == htq_pkg::OP_REMOVE) begin
            pull_slot(pos);
          end else begin
            // Re-timing to the same time leaves the heap as it is.
            old_e = sh_exp[pos];
            sh_exp[pos] = it.expiration;
            if (it.expiration < old_e) climb(pos);
            else if (it.expiration > old_e) descend(pos);
          end
          queue_result(make_beat(htq_pkg::STATUS_OK, 0, 0, 0, 0));
        end
      end
      htq_pkg::OP_POP: begin
        if (sh_count == 0) begin
          queue_result(make_beat(htq_pkg::STATUS_EMPTY, 0, 0, 0, 0));
        end else begin
          id = sh_id[0]; g = sh_gen[0]; e = sh_exp[0];
          pull_slot(0);
          queue_result(make_beat(htq_pkg::STATUS_OK, 1, id, g, e));
        end
      end
      htq_pkg::OP_EXPIRE: begin
        // A burst limit of zero behaves as one; above the hard cap it clamps.
        burst = (sh_burst < 1) ? 1 : ((sh_burst > BURST_CAP) ? BURST_CAP : sh_burst);
        n = 0;
        while (n < burst && sh_count > 0 && sh_exp[0] <= it.now_time) begin
          id = sh_id[0]; g = sh_gen[0]; e = sh_exp[0];
          pull_slot(0);
          b = make_beat(htq_pkg::STATUS_OK, 1, id, g, e);
          b.last = 1'b0;
          queue_result(b);
          n++;
        end
        if (n == 0) begin
          queue_result(make_beat(htq_pkg::STATUS_NONE_DUE, 0, 0, 0, 0));
        end else begin
          b = take_newest();
          b.last = 1'b1;
          b.more_pending = (sh_count > 0 && sh_exp[0] <= it.now_time);
          queue_result(b);
        end
      end
      // Unknown op codes change nothing and answer ok.
      default: queue_result(make_beat(htq_pkg::STATUS_OK, 0, 0, 0, 0));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Out channel: the receiver's ready and the result checker.
  // --------------------------------------------------------------------------
  int stall_pct = 0;
  int idle_pct  = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // The receiver runs on its own; a hold request from the stimulus side
  // turns into a long, counted stretch of ready low.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    htq_pkg::htq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.out_id != want.out_id)
          report_mismatch("out_id", out_data.out_id, want.out_id);
        if (out_data.out_generation != want.out_generation)
          report_mismatch("out_generation", out_data.out_generation, want.out_generation);
        if (out_data.out_expiration != want.out_expiration)
          report_mismatch("out_expiration", out_data.out_expiration, want.out_expiration);
        if (out_data.queue_count != want.queue_count)
          report_mismatch("queue_count", out_data.queue_count, want.queue_count);
        if (out_data.head_expiration != want.head_expiration)
          report_mismatch("head_expiration", out_data.head_expiration, want.head_expiration);
        if (out_data.last != want.last)
          report_mismatch("last", out_data.last, want.last);
        if (out_data.more_pending != want.more_pending)
          report_mismatch("more_pending", out_data.more_pending, want.more_pending);
      end
    end
  end

  // Watchdog: a long run of cycles without a beat on either channel means
  // the block has hung.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // In channel and configuration drivers.
  // --------------------------------------------------------------------------

  // Offer one beat, holding it until accepted, then predict its results.
  // Random idle cycles go in front so gaps land on every phase of the work.
  task automatic send_item(htq_pkg::htq_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(it);
  endtask

  // Registers change only once every result is out and the sequencer has
  // had time to finish any trailing heap repair.
  task automatic write_reg(logic [htq_pkg::CFG_IDX_W-1:0] idx, int val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[htq_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == htq_pkg::REG_MAX_ENTRIES) sh_max_entries = val & 9'h1FF;
    else if (idx == htq_pkg::REG_BURST_LIMIT) sh_burst = val & 7'h7F;
  endtask

  // --------------------------------------------------------------------------
  // Directed table. A row either writes a register or sends an item; rows
  // whose answer is plain from the state are typed in, the rest predicted.
  // --------------------------------------------------------------------------
  typedef struct {
    bit                            is_reg;
    logic [htq_pkg::CFG_IDX_W-1:0] reg_idx;
    int                            reg_val;
    htq_pkg::htq_in_t              item;
    bit                            typed;
    htq_pkg::htq_out_t             answer;
  } step_t;

  step_t plan[$];

  function automatic htq_pkg::htq_in_t mk_item(logic [2:0] op, logic [7:0] id, logic [7:0] g,
                                               logic [47:0] e, logic [47:0] n);
    htq_pkg::htq_in_t it;
    it.op = op; it.timer_id = id; it.generation = g;
    it.expiration = e; it.now_time = n;
    return it;
  endfunction

  function automatic void add_item(htq_pkg::htq_in_t it);
    step_t s;
    s = '{default: '0};
    s.item = it;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_typed(htq_pkg::htq_in_t it, htq_pkg::status_e st, int cnt,
                                    logic [47:0] head);
    step_t s;
    s = '{default: '0};
    s.item = it;
    s.typed = 1'b1;
    s.answer = '0;
    s.answer.status = st;
    s.answer.queue_count = cnt[8:0];
    s.answer.head_expiration = head;
    s.answer.last = 1'b1;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_reg(logic [htq_pkg::CFG_IDX_W-1:0] idx, int val);
    step_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void build_plan();
    // Empty queue answers.
    add_typed(mk_item(htq_pkg::OP_POP, 0, 0, 0, 0), htq_pkg::STATUS_EMPTY, 0, 0);
    add_typed(mk_item(htq_pkg::OP_EXPIRE, 0, 0, 0, MAX_TIME), htq_pkg::STATUS_NONE_DUE, 0, 0);
    add_typed(mk_item(htq_pkg::OP_REMOVE, 5, 0, 0, 0), htq_pkg::STATUS_NOT_FOUND, 0, 0);
    add_typed(mk_item(3'd7, 8'hFF, 8'hFF, MAX_TIME, MAX_TIME), htq_pkg::STATUS_OK, 0, 0);
    // Field extremes, duplicate, stale generation, re-time to the same time.
    add_typed(mk_item(htq_pkg::OP_INSERT, 0, 0, MAX_TIME, 0), htq_pkg::STATUS_OK, 1, MAX_TIME);
    add_typed(mk_item(htq_pkg::OP_INSERT, 8'hFF, 8'hFF, 0, MAX_TIME), htq_pkg::STATUS_OK, 2, 0);
    add_typed(mk_item(htq_pkg::OP_INSERT, 0, 8'h55, 48'd7, 0), htq_pkg::STATUS_DUPLICATE, 2, 0);
    add_typed(mk_item(htq_pkg::OP_REMOVE, 8'hFF, 8'h01, 0, 0), htq_pkg::STATUS_STALE, 2, 0);
    add_typed(mk_item(htq_pkg::OP_UPDATE, 8'hFF, 8'hFF, 0, 0), htq_pkg::STATUS_OK, 2, 0);
    // Equal expirations stay in arrival order at the top.
    add_item(mk_item(htq_pkg::OP_INSERT, 10, 3, 48'd100, 0));
    add_item(mk_item(htq_pkg::OP_INSERT, 11, 4, 48'd100, 0));
    add_item(mk_item(htq_pkg::OP_UPDATE, 0, 0, 48'd50, 0));
    add_item(mk_item(htq_pkg::OP_POP, 0, 0, 0, 0));
    add_item(mk_item(htq_pkg::OP_EXPIRE, 0, 0, 0, 48'd100));
    add_item(mk_item(htq_pkg::OP_REMOVE, 0, 0, 0, 0));
    // A zero capacity refuses every insert as full.
    add_reg(htq_pkg::REG_MAX_ENTRIES, 0);
    add_item(mk_item(htq_pkg::OP_INSERT, 11, 4, 48'd1, 0));
    add_item(mk_item(htq_pkg::OP_INSERT, 20, 1, 48'd1, 0));
    add_reg(htq_pkg::REG_MAX_ENTRIES, 511);
    // A zero burst acts as one and flags the rest as pending.
    add_reg(htq_pkg::REG_BURST_LIMIT, 0);
    add_item(mk_item(htq_pkg::OP_INSERT, 30, 9, 48'd5, 0));
    add_item(mk_item(htq_pkg::OP_INSERT, 31, 9, 48'd5, 0));
    add_item(mk_item(htq_pkg::OP_INSERT, 32, 9, 48'd3, 0));
    add_item(mk_item(htq_pkg::OP_EXPIRE, 0, 0, 0, 48'd10));
    // An oversized burst clamps to the hard cap and drains everything due.
    add_reg(htq_pkg::REG_BURST_LIMIT, 127);
    add_item(mk_item(htq_pkg::OP_EXPIRE, 0, 0, 0, MAX_TIME));
    add_item(mk_item(htq_pkg::OP_POP, 0, 0, 0, 0));
  endfunction

  // --------------------------------------------------------------------------
  // Random items. Ids come mostly from a small pool so that duplicates,
  // removes and updates meet queued timers; generations mostly match the
  // queued one. Times cluster near a moving clock, with rare full-width
  // values so every bit of both time fields toggles.
  // --------------------------------------------------------------------------
  logic [47:0] clock_now = 48'd1000;

  function automatic logic [47:0] wide_rand();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic htq_pkg::htq_in_t random_item();
    htq_pkg::htq_in_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      it.op = htq_pkg::OP_INSERT;
    else if (pick < 50) it.op = htq_pkg::OP_REMOVE;
    else if (pick < 65) it.op = htq_pkg::OP_UPDATE;
    else if (pick < 75) it.op = htq_pkg::OP_POP;
    else if (pick < 95) it.op = htq_pkg::OP_EXPIRE;
    else                it.op = 3'($urandom_range(7, 5));
    it.timer_id = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    if (id_queued[it.timer_id] && $urandom_range(99) < 80)
      it.generation = sh_gen[id_slot[it.timer_id]];
    else
      it.generation = 8'($urandom_range(255));
    it.expiration = ($urandom_range(99) < 8) ? wide_rand()
                                              : clock_now + 48'($urandom_range(300));
    it.now_time   = ($urandom_range(99) < 8) ? wide_rand()
                                              : clock_now + 48'($urandom_range(150));
    clock_now = clock_now + 48'($urandom_range(20));
    return it;
  endfunction

  task automatic random_phase(int idle, int stall, int cap, int burst, bit squeeze);
    write_reg(htq_pkg::REG_MAX_ENTRIES, cap);
    write_reg(htq_pkg::REG_BURST_LIMIT, burst);
    idle_pct  = idle;
    stall_pct = stall;
    // The long hold-off backs the block up while items keep coming.
    if (squeeze) hold_req++;
    for (int k = 0; k < PHASE_LEN; k++) send_item(random_item());
    in_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      id_queued[i] = 1'b0;
      id_slot[i] = 0;
    end
    sh_count = 0;
    sh_max_entries = 256;
    sh_burst = 16;
    build_plan();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item);
        // The typed answer stands in for the predicted one.
        if (plan[i].typed) begin
          void'(take_newest());
          queue_result(plan[i].answer);
        end
      end
    end
    in_valid <= 1'b0;

    random_phase(0, 0, 256, 16, 1'b1);
    random_phase(69, 0, $urandom_range(8, 1), 1, 1'b0);
    random_phase(0, 69, 256, 64, 1'b0);
    random_phase(20, 20, $urandom_range(40, 4), $urandom_range(8, 2), 1'b0);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
